@@ rtl/fsla_pkg.sv @@
// ----------------------------------------------------------------------------
// Free-list allocator package
// Shared types, constants and the object-size rounding function.
// ----------------------------------------------------------------------------
package fsla_pkg;

    localparam int SLOT_BYTES = 8;
    localparam int SLOT_SHIFT = 3;
    localparam int NUM_REGS   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int SIZE_REG_W = 13;
    localparam int RSIZE_W    = SIZE_REG_W + 1;
    localparam int ADDR_W     = 15;
    localparam int COUNT_W    = 32;

    localparam logic [SIZE_REG_W-1:0] SIZE_RESET = SIZE_REG_W'(SLOT_BYTES);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [SIZE_REG_W-1:0] data;
    } t_cfg_wr;

    typedef logic [NUM_REGS-1:0][SIZE_REG_W-1:0] t_size_array;

    // Rounds an object size up to a whole number of slots, at least one slot.
    function automatic logic [RSIZE_W-1:0] round_size(input logic [SIZE_REG_W-1:0] size);
        logic [RSIZE_W-1:0] r;
        r = {1'b0, size} + RSIZE_W'(SLOT_BYTES - 1);
        r[SLOT_SHIFT-1:0] = '0;
        if (r == '0) begin
            r = RSIZE_W'(SLOT_BYTES);
        end
        return r;
    endfunction

endpackage

@@ rtl/fsla_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Object size registers
// One size register per cache, written through the plain write port.
// ----------------------------------------------------------------------------
module fsla_cfg_regs
    import fsla_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg_wr     i_wr,
    output t_size_array o_sizes
);

    t_size_array r_sizes;
    t_size_array n_sizes;

    always_comb begin
        n_sizes = r_sizes;
        if (i_wr.we) begin
            n_sizes[i_wr.index] = i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sizes <= {NUM_REGS{SIZE_RESET}};
        end else begin
            r_sizes <= n_sizes;
        end
    end

    assign o_sizes = r_sizes;

endmodule

@@ rtl/fsla_link_mem.sv @@
// ----------------------------------------------------------------------------
// Link memory
// One next link per slot: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fsla_link_mem #(
    parameter int DEPTH = 4096,
    parameter int DW    = 13
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fixed_size_free_list_allocator_core.sv @@
// One item is in flight at a time: requests are taken only in the idle state.
// Free, failed allocate and unknown cache: the result is registered on acceptance.
// Allocate from a non-empty list: a link memory read, then the head update.
// Allocate from an empty list: a refill start, then one link write for each of the
// floor(PAGE_BYTES/size) objects through the single write port, then the read and pop.
// Synchronous reset: lists empty, counts and pages zero, sizes 8 bytes, links not cleared.
// ----------------------------------------------------------------------------
// Fixed-size free-list allocator core
// Object caches over a page pool, each with a linked free list in a link memory.
// ----------------------------------------------------------------------------
module fixed_size_free_list_allocator_core
    import fsla_pkg::*;
#(
    parameter int NUM_CACHES = 4,
    parameter int POOL_PAGES = 8,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SIZE_REG_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_opcode,
    input  logic [1:0]            i_cache_id,
    input  logic [ADDR_W-1:0]     i_obj_addr,
    input  logic                  i_addr_null,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [ADDR_W-1:0]     o_result_addr,
    output logic                  o_success,
    output logic [COUNT_W-1:0]    o_alloc_count
);

    localparam int POOL_BYTES = POOL_PAGES * PAGE_BYTES;
    localparam int SLOT_COUNT = POOL_BYTES / SLOT_BYTES;
    localparam int PAGE_SLOTS = PAGE_BYTES / SLOT_BYTES;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int LINK_W     = SLOT_W + 1;
    localparam int OFF_W      = $clog2(3 * PAGE_BYTES + 1);
    localparam int PG_W       = $clog2(POOL_PAGES + 1);
    localparam int CID_W      = (NUM_CACHES > 1) ? $clog2(NUM_CACHES) : 1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_REFILL = 4'b0010,
        S_RD     = 4'b0100,
        S_POP    = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [NUM_CACHES-1:0] r_head_vld, n_head_vld;
    logic [SLOT_W-1:0]     r_head_slot [NUM_CACHES];
    logic [SLOT_W-1:0]     n_head_slot [NUM_CACHES];
    logic [COUNT_W-1:0]    r_count [NUM_CACHES];
    logic [COUNT_W-1:0]    n_count [NUM_CACHES];
    logic [PG_W-1:0]       r_pages, n_pages;
    logic [CID_W-1:0]      r_cidx, n_cidx;
    logic [OFF_W-1:0]      r_size, n_size;
    logic [OFF_W-1:0]      r_off, n_off;
    logic [SLOT_W-1:0]     r_base_slot, n_base_slot;
    logic                  r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]     r_out_addr, n_out_addr;
    logic                  r_out_success, n_out_success;
    logic [COUNT_W-1:0]    r_out_count, n_out_count;

    t_cfg_wr               w_cfg_wr;
    t_size_array           w_sizes;
    logic                  w_in_acc;
    logic [CID_W-1:0]      w_cidx;
    logic                  w_in_range;
    logic [RSIZE_W-1:0]    w_rounded;
    logic [OFF_W-1:0]      w_eff_size;
    logic [SLOT_W-1:0]     w_free_slot;
    logic [SLOT_W-1:0]     w_walk_slot;
    logic [OFF_W-1:0]      w_next_off;
    logic                  w_walk_last;
    logic                  w_mem_we;
    logic [SLOT_W-1:0]     w_mem_waddr;
    logic [LINK_W-1:0]     w_mem_wdata;
    logic                  w_mem_re;
    logic [SLOT_W-1:0]     w_mem_raddr;
    logic [LINK_W-1:0]     w_mem_rdata;

    assign w_cfg_wr.we    = i_cfg_we;
    assign w_cfg_wr.index = i_cfg_index;
    assign w_cfg_wr.data  = i_cfg_data;

    fsla_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_cfg_wr),
        .o_sizes (w_sizes)
    );

    fsla_link_mem #(
        .DEPTH (SLOT_COUNT),
        .DW    (LINK_W)
    ) u_link_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_cidx     = CID_W'(i_cache_id);
    assign w_in_range = 32'(i_cache_id) < NUM_CACHES;

    // Sizes beyond a page are held to one object per page.
    assign w_rounded   = round_size(w_sizes[i_cache_id]);
    assign w_eff_size  = (32'(w_rounded) > PAGE_BYTES) ? OFF_W'(PAGE_BYTES)
                                                       : OFF_W'(w_rounded);
    assign w_free_slot = SLOT_W'(i_obj_addr >> SLOT_SHIFT);

    assign w_walk_slot = r_base_slot + SLOT_W'(r_off >> SLOT_SHIFT);
    assign w_next_off  = r_off + r_size;
    // The current object is the last one when the next one would not fit the page.
    assign w_walk_last = (32'(w_next_off) + 32'(r_size)) > PAGE_BYTES;

    always_comb begin
        n_state       = r_state;
        n_head_vld    = r_head_vld;
        n_head_slot   = r_head_slot;
        n_count       = r_count;
        n_pages       = r_pages;
        n_cidx        = r_cidx;
        n_size        = r_size;
        n_off         = r_off;
        n_base_slot   = r_base_slot;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_addr    = r_out_addr;
        n_out_success = r_out_success;
        n_out_count   = r_out_count;
        w_mem_we      = 1'b0;
        w_mem_waddr   = w_free_slot;
        w_mem_wdata   = '0;
        w_mem_re      = 1'b0;
        w_mem_raddr   = r_head_slot[r_cidx];

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cidx = w_cidx;
                    if (!w_in_range) begin
                        n_out_valid   = 1'b1;
                        n_out_addr    = '0;
                        n_out_success = 1'b0;
                        n_out_count   = '0;
                    end else if (i_opcode == OP_FREE) begin
                        n_out_valid   = 1'b1;
                        n_out_addr    = '0;
                        n_out_success = 1'b0;
                        n_out_count   = r_count[w_cidx];
                        if (!i_addr_null && (32'(i_obj_addr) < POOL_BYTES)) begin
                            w_mem_we             = 1'b1;
                            w_mem_waddr          = w_free_slot;
                            w_mem_wdata          = {r_head_vld[w_cidx], r_head_slot[w_cidx]};
                            n_head_vld[w_cidx]   = 1'b1;
                            n_head_slot[w_cidx]  = w_free_slot;
                            n_out_success        = 1'b1;
                        end
                    end else if (r_head_vld[w_cidx]) begin
                        w_mem_re    = 1'b1;
                        w_mem_raddr = r_head_slot[w_cidx];
                        n_state     = S_POP;
                    end else if (32'(r_pages) < POOL_PAGES) begin
                        n_size      = w_eff_size;
                        n_off       = '0;
                        n_base_slot = SLOT_W'(32'(r_pages) * PAGE_SLOTS);
                        n_pages     = r_pages + PG_W'(1);
                        n_state     = S_REFILL;
                    end else begin
                        n_out_valid   = 1'b1;
                        n_out_addr    = '0;
                        n_out_success = 1'b0;
                        n_out_count   = r_count[w_cidx];
                    end
                end
            end
            S_REFILL: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = w_walk_slot;
                if (w_walk_last) begin
                    // The last object links to the old, empty list head.
                    w_mem_wdata         = {r_head_vld[r_cidx], r_head_slot[r_cidx]};
                    n_head_vld[r_cidx]  = 1'b1;
                    n_head_slot[r_cidx] = r_base_slot;
                    n_state             = S_RD;
                end else begin
                    w_mem_wdata = {1'b1, w_walk_slot + SLOT_W'(r_size >> SLOT_SHIFT)};
                    n_off       = w_next_off;
                end
            end
            S_RD: begin
                w_mem_re    = 1'b1;
                w_mem_raddr = r_head_slot[r_cidx];
                n_state     = S_POP;
            end
            S_POP: begin
                n_head_vld[r_cidx]  = w_mem_rdata[LINK_W-1];
                n_head_slot[r_cidx] = w_mem_rdata[SLOT_W-1:0];
                n_count[r_cidx]     = r_count[r_cidx] + COUNT_W'(1);
                n_out_valid         = 1'b1;
                n_out_addr          = ADDR_W'({r_head_slot[r_cidx], {SLOT_SHIFT{1'b0}}});
                n_out_success       = 1'b1;
                n_out_count         = r_count[r_cidx] + COUNT_W'(1);
                n_state             = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head_vld  <= '0;
            r_pages     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CACHES; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_head_vld  <= n_head_vld;
            r_pages     <= n_pages;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_slot   <= n_head_slot;
        r_cidx        <= n_cidx;
        r_size        <= n_size;
        r_off         <= n_off;
        r_base_slot   <= n_base_slot;
        r_out_addr    <= n_out_addr;
        r_out_success <= n_out_success;
        r_out_count   <= n_out_count;
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_addr = r_out_addr;
    assign o_success     = r_out_success;
    assign o_alloc_count = r_out_count;

    a_pages_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pages) <= POOL_PAGES)
        else $error("pages used beyond the pool");

    a_pop_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> r_head_vld[r_cidx])
        else $error("pop from an empty list");

    a_walk_in_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REFILL) |-> ((32'(r_off) + 32'(r_size)) <= PAGE_BYTES))
        else $error("refill walked past the page");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> ((r_state == S_IDLE) || (r_state == S_REFILL)))
        else $error("link write outside free or refill");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (o_out_valid && o_success))
        else $error("pop gave no successful item");

endmodule
